@@ rtl/bps_pkg.sv @@
// Shared types and constants of the buzzer pattern sequencer.
package bps_pkg;

	typedef enum logic {
		REQ_SET  = 1'b0,
		REQ_TICK = 1'b1
	} req_t;

	typedef enum logic [2:0] {
		MODE_OFF        = 3'd0,
		MODE_ON         = 3'd1,
		MODE_TROUBLE    = 3'd2,
		MODE_ALARM      = 3'd3,
		MODE_FOUR_BEEPS = 3'd4,
		MODE_ONE_MINUTE = 3'd5
	} mode_t;

	localparam int LIMIT_BITS  = 10;
	localparam int REPORT_BITS = 4;

	localparam logic [31:0] PAT_TROUBLE    = 32'h0000_0007;
	localparam logic [31:0] PAT_ALARM      = 32'h0000_0C1F;
	localparam logic [31:0] PAT_FOUR_BEEPS = 32'h0000_0003;

	localparam logic [LIMIT_BITS-1:0] LIM_OFF        = LIMIT_BITS'(1);
	localparam logic [LIMIT_BITS-1:0] LIM_FOUR_BEEPS = LIMIT_BITS'(4);
	localparam logic [LIMIT_BITS-1:0] LIM_ONE_MINUTE = LIMIT_BITS'(600);

	// Command from the pipeline to one channel for the word being retired.
	typedef struct packed {
		logic       set;
		logic       tick;
		logic [2:0] mode;
	} chan_cmd_t;

	// Channel status after the command has been applied.
	typedef struct packed {
		logic drive;
		logic active;
	} chan_stat_t;

endpackage

@@ rtl/bps_channel.sv @@
// One channel of the sequencer: pattern, walking mask, on-tick limit and drive bit.
module bps_channel
	import bps_pkg::*;
#(
	parameter int PATTERN_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  chan_cmd_t  cmd,
	output chan_stat_t stat_nxt,
	output logic       drive
);

	logic [PATTERN_BITS-1:0] pat_q, pat_n;
	logic [PATTERN_BITS-1:0] mask_q, mask_n, mask_w, mask_sh;
	logic [LIMIT_BITS-1:0]   lim_q, lim_n, lim_dec;
	logic                    drv_q, drv_n;

	assign lim_dec = lim_q - LIMIT_BITS'(1);

	always_comb begin
		pat_n   = pat_q;
		mask_n  = mask_q;
		mask_w  = mask_q;
		mask_sh = '0;
		lim_n   = lim_q;
		drv_n   = drv_q;
		if (cmd.tick) begin
			drv_n = |(pat_q & mask_q);
			// The limit only runs down while the buzzer is sounding.
			if (drv_n && (lim_q != '0)) begin
				lim_n = lim_dec;
				if (lim_dec == '0) begin
					pat_n  = '0;
					mask_w = '0;
				end
			end
			mask_sh = {mask_w[PATTERN_BITS-2:0], 1'b0};
			mask_n  = (mask_sh == '0) ? PATTERN_BITS'(1) : mask_sh;
		end else if (cmd.set) begin
			unique case (cmd.mode)
				MODE_OFF: begin
					pat_n  = '0;
					lim_n  = LIM_OFF;
					mask_n = '0;
				end
				MODE_ON: begin
					pat_n  = '1;
					lim_n  = '0;
					mask_n = PATTERN_BITS'(1);
				end
				MODE_TROUBLE: begin
					pat_n  = PAT_TROUBLE[PATTERN_BITS-1:0];
					lim_n  = '0;
					mask_n = PATTERN_BITS'(1);
				end
				MODE_ALARM: begin
					pat_n  = PAT_ALARM[PATTERN_BITS-1:0];
					lim_n  = '0;
					mask_n = PATTERN_BITS'(1);
				end
				MODE_FOUR_BEEPS: begin
					pat_n  = PAT_FOUR_BEEPS[PATTERN_BITS-1:0];
					lim_n  = LIM_FOUR_BEEPS;
					mask_n = PATTERN_BITS'(1);
				end
				MODE_ONE_MINUTE: begin
					// The mask keeps its current position.
					pat_n = PAT_ALARM[PATTERN_BITS-1:0];
					lim_n = LIM_ONE_MINUTE;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			mask_q <= '0;
			lim_q  <= '0;
			drv_q  <= 1'b0;
		end else begin
			pat_q  <= pat_n;
			mask_q <= mask_n;
			lim_q  <= lim_n;
			drv_q  <= drv_n;
		end
	end

	assign stat_nxt.drive  = drv_n;
	assign stat_nxt.active = (pat_n != '0);
	assign drive           = drv_q;

endmodule

@@ rtl/buzzer_pattern_sequencer.sv @@
// Top level of the buzzer pattern sequencer: input register, channels, result register.
//
// Usage: each word on the s_axis channel is either a set request (tuser = 0),
// which loads one channel from a mode, or a 100 ms tick (tuser = 1), which
// advances every channel at once. Each accepted word returns exactly one
// result word on m_axis: the drive bit of channels 0 to 3 in bits 3:0 and
// their pattern-active bits in bits 7:4, both as they stand after that word.
// A set request never changes a drive bit; it shows up on the next tick.
// The accepted word lands in the input register and its result in the result
// register, which takes it as soon as it is empty or being read; m_axis_tvalid
// then rises. Throughput: one word per cycle while the receiver keeps up; the
// channel update is a single short compare, decrement and shift per channel.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word, after which s_axis_tready drops until
// the result is taken. Reset clears all patterns, masks, limits and drive
// bits, so every buzzer starts off, and empties both registers.
module buzzer_pattern_sequencer
	import bps_pkg::*;
#(
	parameter int CHANNELS     = 4,
	parameter int PATTERN_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // channel[1:0], mode[4:2], zero[7:5]
	input  logic       s_axis_tuser,  // req_type[0]
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata   // buzzer_drive[3:0], pattern_active[7:4]
);

	localparam int REPORT_CH = (CHANNELS < REPORT_BITS) ? CHANNELS : REPORT_BITS;

	logic       s1_valid_q;
	logic       s1_req_s1;
	logic [1:0] s1_channel_s1;
	logic [2:0] s1_mode_s1;
	logic       m_valid_q;
	logic [7:0] m_data_q;
	logic       advance, go;

	chan_cmd_t  cmd [CHANNELS];
	chan_stat_t stat_nxt [CHANNELS];
	logic [CHANNELS-1:0] drive_vec;

	logic [REPORT_BITS-1:0] rep_drive, rep_active, cur_drive;

	assign advance       = !m_valid_q || m_axis_tready;
	assign go            = s1_valid_q && advance;
	assign s_axis_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			s1_req_s1     <= s_axis_tuser;
			s1_channel_s1 <= s_axis_tdata[1:0];
			s1_mode_s1    <= s_axis_tdata[4:2];
		end
	end

	for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
		assign cmd[i].set  = go && (s1_req_s1 == REQ_SET) && (32'(s1_channel_s1) == i);
		assign cmd[i].tick = go && (s1_req_s1 == REQ_TICK);
		assign cmd[i].mode = s1_mode_s1;

		bps_channel #(
			.PATTERN_BITS(PATTERN_BITS)
		) u_chan (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd[i]),
			.stat_nxt(stat_nxt[i]),
			.drive   (drive_vec[i])
		);
	end

	// Only the first four channels are reported.
	always_comb begin
		rep_drive  = '0;
		rep_active = '0;
		cur_drive  = '0;
		for (int i = 0; i < REPORT_CH; i++) begin
			rep_drive[i]  = stat_nxt[i].drive;
			rep_active[i] = stat_nxt[i].active;
			cur_drive[i]  = drive_vec[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			m_data_q <= {rep_active, rep_drive};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !advance |=> s1_valid_q)
		else $error("input register dropped a word under stall");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> m_axis_tvalid)
		else $error("retired word produced no result");

	a_set_keeps_drive: assert property (@(posedge clk) disable iff (!arst_n)
		go && (s1_req_s1 == REQ_SET) |=> m_axis_tdata[3:0] == $past(cur_drive))
		else $error("set request changed a drive bit");

endmodule

@@ tb/buzzer_pattern_sequencer_tb.sv @@
// Self-checking testbench of the buzzer pattern sequencer with a predicting scoreboard.
`timescale 1ns / 1ps

module buzzer_pattern_sequencer_tb
	import bps_pkg::*;
();

	localparam int NCH   = 4;
	localparam int PBITS = 16;

	typedef struct packed {
		logic [3:0] active;
		logic [3:0] drive;
	} status_word_t;

	// Tracks the channel state word by word and holds the status words still due.
	class buzzer_tracker;
		logic [PBITS-1:0]      pat   [NCH];
		logic [PBITS-1:0]      wmask [NCH];
		logic [LIMIT_BITS-1:0] lim   [NCH];
		logic                  drv   [NCH];
		status_word_t          words_due[$];
		int                    errors;

		function new();
			for (int c = 0; c < NCH; c++) begin
				pat[c]   = '0;
				wmask[c] = '0;
				lim[c]   = '0;
				drv[c]   = 1'b0;
			end
			errors = 0;
		endfunction

		function void load_channel(int c, logic [2:0] mode);
			case (mode)
				MODE_OFF: begin
					pat[c] = '0; lim[c] = LIM_OFF; wmask[c] = '0;
				end
				MODE_ON: begin
					pat[c] = '1; lim[c] = '0; wmask[c] = PBITS'(1);
				end
				MODE_TROUBLE: begin
					pat[c] = PAT_TROUBLE[PBITS-1:0]; lim[c] = '0; wmask[c] = PBITS'(1);
				end
				MODE_ALARM: begin
					pat[c] = PAT_ALARM[PBITS-1:0]; lim[c] = '0; wmask[c] = PBITS'(1);
				end
				MODE_FOUR_BEEPS: begin
					pat[c] = PAT_FOUR_BEEPS[PBITS-1:0]; lim[c] = LIM_FOUR_BEEPS;
					wmask[c] = PBITS'(1);
				end
				// One minute keeps the mask where it stands.
				MODE_ONE_MINUTE: begin
					pat[c] = PAT_ALARM[PBITS-1:0]; lim[c] = LIM_ONE_MINUTE;
				end
				default: ;
			endcase
		endfunction

		function void tick_channel(int c);
			if ((pat[c] & wmask[c]) != '0) begin
				drv[c] = 1'b1;
				if (lim[c] != '0) begin
					lim[c] = lim[c] - 1'b1;
					if (lim[c] == '0) begin
						wmask[c] = '0;
						pat[c]   = '0;
					end
				end
			end else begin
				drv[c] = 1'b0;
			end
			wmask[c] = wmask[c] << 1;
			if (wmask[c] == '0)
				wmask[c] = PBITS'(1);
		endfunction

		function void note_word(req_t req, logic [1:0] ch, logic [2:0] mode);
			status_word_t w;
			if (req == REQ_SET) begin
				if (ch < NCH)
					load_channel(ch, mode);
			end else begin
				for (int c = 0; c < NCH; c++)
					tick_channel(c);
			end
			for (int c = 0; c < 4; c++) begin
				w.drive[c]  = drv[c];
				w.active[c] = (pat[c] != '0);
			end
			words_due.push_back(w);
		endfunction

		function void check_word(logic [7:0] data);
			status_word_t got, want;
			got = data;
			if (words_due.size() == 0) begin
				$error("result word %h arrived with nothing due", data);
				errors++;
				return;
			end
			want = words_due.pop_front();
			if (got.drive !== want.drive) begin
				$error("buzzer_drive expected %h actual %h", want.drive, got.drive);
				errors++;
			end
			if (got.active !== want.active) begin
				$error("pattern_active expected %h actual %h", want.active, got.active);
				errors++;
			end
		endfunction

		function int pending();
			return words_due.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic       s_axis_tuser = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;

	int src_idle_pct = 29;
	int dst_idle_pct = 76;

	buzzer_tracker tracker = new();

	buzzer_pattern_sequencer #(
		.CHANNELS    (NCH),
		.PATTERN_BITS(PBITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Receiver: random stalls, decided at the falling edge.
	initial begin
		forever begin
			@(negedge clk);
			m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_word(m_axis_tdata);
	end

	// Sends one word; the caller stands at a falling edge and is left at one.
	task automatic send_word(req_t req, logic [1:0] ch, logic [2:0] mode);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= {3'b000, mode, ch};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		tracker.note_word(req, ch, mode);
		@(negedge clk);
	endtask

	task automatic send_set(logic [1:0] ch, logic [2:0] mode);
		send_word(REQ_SET, ch, mode);
	endtask

	task automatic send_tick();
		send_word(REQ_TICK, 2'($urandom_range(3)), 3'($urandom_range(7)));
	endtask

	// Mostly ticks with sets sprinkled in; a few sets carry a mode with no meaning.
	// Sets go to channels 0 up to top_ch only.
	task automatic send_random(int count, int tick_pct, int top_ch);
		int n;
		logic [2:0] mode;
		n = 0;
		while (n < count) begin
			if ($urandom_range(99) < tick_pct) begin
				send_tick();
				n++;
			end else begin
				if ($urandom_range(15) == 0)
					mode = 3'($urandom_range(7, 6));
				else begin
					mode = 3'($urandom_range(5));
					n++;
				end
				send_set(2'($urandom_range(top_ch)), mode);
			end
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: every mode on at least one channel, ignored modes and set
		// words between ticks.
		send_tick();
		send_set(2'd0, MODE_ONE_MINUTE);
		send_tick();
		send_tick();
		send_set(2'd0, MODE_ON);
		send_set(2'd1, MODE_TROUBLE);
		send_set(2'd2, MODE_ALARM);
		send_set(2'd3, MODE_FOUR_BEEPS);
		send_tick();
		send_tick();
		send_tick();
		send_set(2'd1, 3'd6);
		send_set(2'd2, 3'd7);
		send_tick();
		send_set(2'd3, MODE_OFF);
		send_set(2'd0, MODE_OFF);
		send_tick();
		send_set(2'd1, MODE_ONE_MINUTE);
		send_set(2'd3, MODE_ONE_MINUTE);
		send_tick();
		send_set(2'd2, MODE_OFF);
		send_tick();
		send_tick();

		send_random(100, 75, 3);

		src_idle_pct = 76;
		dst_idle_pct = 29;
		send_random(100, 75, 3);

		src_idle_pct = 0;
		dst_idle_pct = 0;
		send_random(100, 75, 3);

		// Long soak: channel 3 in one-minute mode runs its limit down to zero
		// while the other channels keep getting set.
		send_set(2'd3, MODE_ONE_MINUTE);
		send_random(1450, 98, 2);

		s_axis_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ files.f @@
rtl/bps_pkg.sv
rtl/bps_channel.sv
rtl/buzzer_pattern_sequencer.sv
tb/buzzer_pattern_sequencer_tb.sv
